// ----- hw/rtl/wtr_pkg.sv -----
package wtr_pkg;

  localparam int unsigned ROW_W = 6;
  localparam int unsigned ADDR_W = 13;
  localparam int unsigned COLOR_W = 4;

  localparam logic [ROW_W-1:0] MAX_ROW = 6'd55;
  localparam logic [ROW_W-1:0] RESET_ROW = 6'd28;
  localparam logic [7:0] AMP_OFFSET = 8'd127;

  // floor(x / 1152 * 256) = floor(amp * 2 / 9) = (amp * 3642) >> 14, exact for 8-bit amp
  localparam logic [11:0] ROW_RECIP = 12'd3642;
  localparam int unsigned ROW_SHIFT = 14;
  // floor(row / 3) = (row * 171) >> 9, exact for rows up to 55
  localparam logic [7:0] THIRD_RECIP = 8'd171;
  localparam int unsigned THIRD_SHIFT = 9;

  typedef struct packed {
    logic load;
    logic map;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } sts_t;

  function automatic logic [COLOR_W-1:0] gradient(input logic [3:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      4'd0:    c = 4'd15;
      4'd1:    c = 4'd14;
      4'd2:    c = 4'd13;
      4'd3:    c = 4'd12;
      4'd4:    c = 4'd11;
      4'd5:    c = 4'd10;
      4'd6:    c = 4'd9;
      4'd7:    c = 4'd8;
      4'd8:    c = 4'd8;
      4'd9:    c = 4'd9;
      4'd10:   c = 4'd10;
      4'd11:   c = 4'd11;
      4'd12:   c = 4'd12;
      4'd13:   c = 4'd13;
      4'd14:   c = 4'd14;
      default: c = 4'd15;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/wtr_ctrl.sv -----
module wtr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wtr_pkg::sts_t sts,
  output wtr_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAP  = 2'd1;
  localparam logic [1:0] S_DRAW = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map = 1'b1;
        state_next = S_DRAW;
      end
      S_DRAW: begin
        // advance one pixel whenever the output register can take a word
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/wtr_datapath.sv -----
module wtr_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  wtr_pkg::cmd_t                  cmd,
  output wtr_pkg::sts_t                  sts,
  input  logic [7:0]                     position_code,
  input  logic [7:0]                     amplitude,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wtr_pkg::ADDR_W-1:0]     byte_address,
  output logic                           high_nibble,
  output logic [wtr_pkg::COLOR_W-1:0]    pixel_color,
  output logic                           last_write
);

  logic [7:0]                pos;
  logic [7:0]                amp;
  logic [wtr_pkg::ROW_W-1:0] prev;
  logic [wtr_pkg::ROW_W-1:0] limit;
  logic [wtr_pkg::ROW_W-1:0] y;
  logic                      down;

  logic [7:0]                amp_off;
  logic [19:0]               scaled;
  logic [wtr_pkg::ROW_W-1:0] row_raw;
  logic [wtr_pkg::ROW_W-1:0] row_c;
  logic [13:0]               third_prod;
  logic [3:0]                cidx;
  logic                      last;

  assign amp_off = amp + wtr_pkg::AMP_OFFSET;
  assign scaled = {12'd0, amp_off} * {8'd0, wtr_pkg::ROW_RECIP};
  assign row_raw = scaled[wtr_pkg::ROW_SHIFT +: wtr_pkg::ROW_W];
  assign row_c = (row_raw > wtr_pkg::MAX_ROW) ? wtr_pkg::MAX_ROW : row_raw;

  // going down the run stops just after the old row, otherwise just before it
  assign last = down ? ({1'b0, y} == {1'b0, limit} + 7'd1)
                     : ({1'b0, y} + 7'd1 >= {1'b0, limit});

  assign third_prod = {8'd0, y} * {6'd0, wtr_pkg::THIRD_RECIP};
  assign cidx = third_prod[wtr_pkg::THIRD_SHIFT +: 4] - 4'd1;

  assign sts.out_free = !out_valid || out_ready;
  assign sts.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= wtr_pkg::RESET_ROW;
      out_valid <= 1'b0;
    end else begin
      if (cmd.map) begin
        prev <= row_c;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos <= position_code;
      amp <= amplitude;
    end
    if (cmd.map) begin
      limit <= prev;
      y <= row_c;
      down <= row_c > prev;
    end
    if (cmd.emit) begin
      y <= down ? y - 6'd1 : y + 6'd1;
      byte_address <= {y[5:3], pos[7:3], y[2:0], pos[2:1]};
      high_nibble <= pos[0];
      pixel_color <= wtr_pkg::gradient(cidx);
      last_write <= last;
    end
  end

endmodule

// ----- hw/rtl/waveform_trace_rasterizer.sv -----
// After a sample is accepted, the controller maps it to a row, then draws the run;
// the pixel words come from a single shared row stepper, one per cycle while
// out_ready holds; a sample draws n pixels (1..55) before the next is taken.
// Reset (rst, synchronous, active high) returns to idle, drops out_valid
// and sets the previous row to 28.
module waveform_trace_rasterizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  position_code,
  input  logic [7:0]  amplitude,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] byte_address,
  output logic        high_nibble,
  output logic [3:0]  pixel_color,
  output logic        last_write
);

  wtr_pkg::cmd_t cmd;
  wtr_pkg::sts_t sts;

  wtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wtr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .position_code (position_code),
    .amplitude     (amplitude),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_address  (byte_address),
    .high_nibble   (high_nibble),
    .pixel_color   (pixel_color),
    .last_write    (last_write)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int TILE_ROW_STRIDE = 1024;
  localparam int TILE_BYTES = 32;
  localparam int ROW_DIVISOR = 1152;
  localparam int RANDOM_COLUMNS = 465;
  localparam int CALM_TAIL = 60;
  localparam int DIRECTED_N = 15;

  typedef struct packed {
    logic [wtr_pkg::ADDR_W-1:0]  addr;
    logic                        hi;
    logic [wtr_pkg::COLOR_W-1:0] color;
    logic                        last;
  } pixel_word_t;

  typedef struct packed {
    bit          typed;
    pixel_word_t word;
  } column_note_t;

  typedef struct packed {
    logic [7:0]                  pc;
    logic [7:0]                  amp;
    bit                          typed;
    logic [wtr_pkg::ADDR_W-1:0]  addr;
    logic                        hi;
    logic [wtr_pkg::COLOR_W-1:0] color;
  } column_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] position_code;
  logic [7:0] amplitude;
  logic out_valid;
  logic out_ready;
  logic [12:0] byte_address;
  logic high_nibble;
  logic [3:0] pixel_color;
  logic last_write;

  waveform_trace_rasterizer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .position_code(position_code),
    .amplitude(amplitude),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .byte_address(byte_address),
    .high_nibble(high_nibble),
    .pixel_color(pixel_color),
    .last_write(last_write)
  );

  logic [wtr_pkg::COLOR_W-1:0] shade_ramp [16] = '{
    4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  // single-pixel columns carry their whole word; the rest come from the trace model
  column_row_t directed_cols [DIRECTED_N] = '{
    '{8'h00, 8'd0,   1'b1, 13'd3088, 1'b0, 4'd8},
    '{8'hFF, 8'd0,   1'b1, 13'd4083, 1'b1, 4'd8},
    '{8'hAA, 8'd128, 1'b0, 13'd0,    1'b0, 4'd0},
    '{8'h55, 8'd128, 1'b1, 13'd6494, 1'b1, 4'd14},
    '{8'h3C, 8'd129, 1'b0, 13'd0,    1'b0, 4'd0},
    '{8'h01, 8'd133, 1'b1, 13'd0,    1'b1, 4'd15},
    '{8'h02, 8'd127, 1'b0, 13'd0,    1'b0, 4'd0},
    '{8'h04, 8'd126, 1'b1, 13'd6174, 1'b0, 4'd14},
    '{8'hC3, 8'd134, 1'b0, 13'd0,    1'b0, 4'd0},
    '{8'h08, 8'd136, 1'b1, 13'd36,   1'b0, 4'd15},
    '{8'h77, 8'd255, 1'b0, 13'd0,    1'b0, 4'd0},
    '{8'hE6, 8'd200, 1'b0, 13'd0,    1'b0, 4'd0},
    '{8'h19, 8'd50,  1'b0, 13'd0,    1'b0, 4'd0},
    '{8'hF8, 8'd64,  1'b0, 13'd0,    1'b0, 4'd0},
    '{8'h80, 8'd130, 1'b0, 13'd0,    1'b0, 4'd0}
  };

  pixel_word_t pixel_words [$];
  column_note_t column_notes [$];
  logic [wtr_pkg::ROW_W-1:0] trace_row = wtr_pkg::RESET_ROW;
  bit calm = 1'b0;
  int errors = 0;
  int columns_taken = 0;
  int words_checked = 0;
  int single_runs = 0;
  int longest_run = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Map the amplitude to a row and queue one word per pixel of the vertical run.
  function automatic int trace_column(input logic [7:0] pc, input logic [7:0] amp,
                                      input bit keep);
    logic [7:0] wrapped;
    int row;
    int prev;
    int y;
    int n;
    int a;
    bit down;
    pixel_word_t w;
    wrapped = amp + wtr_pkg::AMP_OFFSET;
    row = (int'(wrapped) * 256) / ROW_DIVISOR;
    if (row > int'(wtr_pkg::MAX_ROW)) row = int'(wtr_pkg::MAX_ROW);
    prev = int'(trace_row);
    down = row > prev;
    y = row;
    n = 0;
    do begin
      a = (y >> 3) * TILE_ROW_STRIDE + (y & 7) * 4 + int'(pc[2:1])
          + int'(pc[7:3]) * TILE_BYTES;
      w.addr = a[wtr_pkg::ADDR_W-1:0];
      w.hi = pc[0];
      w.color = shade_ramp[((y / 3) - 1) & 15];
      w.last = down ? (y - 1 <= prev) : (y + 1 >= prev);
      if (keep) pixel_words.push_back(w);
      n++;
      y = down ? y - 1 : y + 1;
    end while (down ? (y > prev) : (y < prev));
    trace_row = row[wtr_pkg::ROW_W-1:0];
    return n;
  endfunction

  column_note_t note;
  pixel_word_t got;
  pixel_word_t want;
  int run_len;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (column_notes.size() == 0) begin
          note = '0;
        end else begin
          note = column_notes.pop_front();
        end
        run_len = trace_column(position_code, amplitude, !note.typed);
        if (note.typed) pixel_words.push_back(note.word);
        columns_taken++;
        if (run_len == 1) single_runs++;
        if (run_len > longest_run) longest_run = run_len;
      end
      if (out_valid && out_ready) begin
        got = {byte_address, high_nibble, pixel_color, last_write};
        if (pixel_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word addr=%0d hi=%0b color=%0d last=%0b",
                   $time, got.addr, got.hi, got.color, got.last);
        end else begin
          want = pixel_words.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected addr=%0d hi=%0b color=%0d last=%0b",
                     $time, want.addr, want.hi, want.color, want.last);
            $display("%0t:          actual   addr=%0d hi=%0b color=%0d last=%0b",
                     $time, got.addr, got.hi, got.color, got.last);
          end
        end
        words_checked++;
      end
    end
  end

  // Hold the column on the port until it is taken.
  task automatic offer_column(input logic [7:0] pc, input logic [7:0] amp, input bit typed,
                              input pixel_word_t word);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    column_notes.push_back('{typed, word});
    in_valid <= 1'b1;
    position_code <= pc;
    amplitude <= amp;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    forever begin
      if (calm || $urandom_range(0, 5) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [7:0] amp;
    logic [7:0] last_amp;
    rst <= 1'b1;
    in_valid <= 1'b0;
    position_code <= 8'd0;
    amplitude <= 8'd0;
    last_amp = 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_cols[i]) begin
      offer_column(directed_cols[i].pc, directed_cols[i].amp, directed_cols[i].typed,
                   '{directed_cols[i].addr, directed_cols[i].hi, directed_cols[i].color,
                     1'b1});
      last_amp = directed_cols[i].amp;
    end

    for (int i = 0; i < RANDOM_COLUMNS; i++) begin
      if (i >= RANDOM_COLUMNS - CALM_TAIL) calm = 1'b1;
      // repeat amplitudes and hover around the clamp and wrap points now and then
      case ($urandom_range(0, 9))
        0, 1: amp = last_amp;
        2: amp = 8'($urandom_range(120, 140));
        default: amp = 8'($urandom);
      endcase
      offer_column(8'($urandom), amp, 1'b0, '0);
      last_amp = amp;
    end
    in_valid <= 1'b0;

    while (pixel_words.size() != 0 || column_notes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("drew %0d sample columns, compared %0d pixel words", columns_taken,
             words_checked);
    $display("single-pixel columns: %0d, longest run: %0d pixels", single_runs, longest_run);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout: pixel stream stalled");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
